// File: hw/rtl/ospl_pkg.sv
// ----------------------------------------------------------------------------
// ospl_pkg
// Shared types, codes and constants of the operator scan list parser.
// ----------------------------------------------------------------------------
package ospl_pkg;

	// name buffer lengths of the destination list, positions go up to LEN-2
	localparam int LONG_NAME_LEN  = 20;
	localparam int SHORT_NAME_LEN = 20;

	localparam logic [5:0] LONG_POS_LIMIT  = 6'(LONG_NAME_LEN - 1);
	localparam logic [5:0] SHORT_POS_LIMIT = 6'(SHORT_NAME_LEN - 1);

	localparam logic [7:0] CAPACITY_RESET = 8'd16;

	// operation codes
	localparam logic OP_PARSE   = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// event codes
	localparam logic [2:0] EV_STATUS     = 3'd0;
	localparam logic [2:0] EV_LONG_CHAR  = 3'd1;
	localparam logic [2:0] EV_SHORT_CHAR = 3'd2;
	localparam logic [2:0] EV_NUMBER     = 3'd3;
	localparam logic [2:0] EV_CLOSE      = 3'd4;

	// term codes inside a bracket
	localparam logic [1:0] TERM_STATUS = 2'd0;
	localparam logic [1:0] TERM_LONG   = 2'd1;
	localparam logic [1:0] TERM_SHORT  = 2'd2;
	localparam logic [1:0] TERM_NUMBER = 2'd3;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	typedef struct packed {
		logic       operation;
		logic [7:0] byte_value;
	} ospl_req_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  entry_index;
		logic [5:0]  char_pos;
		logic [7:0]  char_value;
		logic [31:0] acc_value;
		logic [7:0]  entry_count;
	} ospl_rsp_t;

endpackage

// File: hw/rtl/operator_scan_list_parser.sv
// ----------------------------------------------------------------------------
// operator_scan_list_parser
// Byte-wise parser of an operator scan reply made of (stat,"long","short",num)
// groups, giving one event word per byte at most.
// ----------------------------------------------------------------------------
// Usage: feed the reply one byte per request word; each word gives zero or one
// event word. A request is registered in the input register and parsed there,
// where the parser state and the event register update together, so a new
// byte can be taken every cycle unless the request side stalls: sustained
// rate one byte per clock. The parse step is a small compare tree plus two
// multiply-by-ten adds, 8-bit for status, 32-bit for number. The request side
// stalls only while the event register holds a word that is not yet taken
// and the byte in the input register would give another one. A restart word
// clears all parser state and the entry index but keeps list_capacity.
// list_capacity must be written only while the block is idle.
module operator_scan_list_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ospl_pkg::ospl_req_t req_word,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ospl_pkg::ospl_rsp_t rsp_word,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_data
);
	import ospl_pkg::*;

	// input register
	logic      req_valid_s1;
	ospl_req_t req_s1;

	// parser state
	logic        bracket_open_q;
	logic        list_ended_q;
	logic [1:0]  term_q;
	logic [5:0]  name_pos_q;
	logic [7:0]  prev_byte_q;
	logic [7:0]  entry_q;
	logic [7:0]  status_acc_q;
	logic [31:0] number_acc_q;
	logic [7:0]  capacity_q;

	// next state and event from the parse step
	logic        bracket_open_d;
	logic        list_ended_d;
	logic [1:0]  term_d;
	logic [5:0]  name_pos_d;
	logic [7:0]  prev_byte_d;
	logic [7:0]  entry_d;
	logic [7:0]  status_acc_d;
	logic [31:0] number_acc_d;
	logic        has_event;
	ospl_rsp_t   event_word;

	logic [7:0]  ch;
	logic [7:0]  status_next;
	logic [31:0] number_next;
	logic        ended_now;
	logic        step_adv;
	logic        rsp_free;

	assign ch = req_s1.byte_value;

	// 10*acc + (ch - '0'), wrapping at the accumulator width
	assign status_next = {status_acc_q[4:0], 3'b000} + {status_acc_q[6:0], 1'b0}
		+ ch - CH_ZERO;
	assign number_next = {number_acc_q[28:0], 3'b000} + {number_acc_q[30:0], 1'b0}
		+ {24'd0, ch} - {24'd0, CH_ZERO};

	// event register can take a word this cycle
	assign rsp_free = !rsp_valid || !rsp_stall;
	// byte in the input register is parsed this cycle
	assign step_adv = req_valid_s1 && (rsp_free || !has_event);
	assign req_stall = req_valid_s1 && !step_adv;

	always_comb begin
		bracket_open_d = bracket_open_q;
		list_ended_d   = list_ended_q;
		term_d         = term_q;
		name_pos_d     = name_pos_q;
		prev_byte_d    = prev_byte_q;
		entry_d        = entry_q;
		status_acc_d   = status_acc_q;
		number_acc_d   = number_acc_q;
		has_event      = 1'b0;
		event_word     = '0;
		event_word.entry_index = entry_q;
		ended_now      = list_ended_q;

		if (req_s1.operation == OP_RESTART) begin
			// full clear, capacity kept
			bracket_open_d = 1'b0;
			list_ended_d   = 1'b0;
			term_d         = TERM_STATUS;
			name_pos_d     = '0;
			prev_byte_d    = CH_NUL;
			entry_d        = '0;
			status_acc_d   = '0;
			number_acc_d   = '0;
		end else if (!(prev_byte_q == CH_NUL && ch == CH_SPACE)) begin
			// a leading comma ends the list before anything else
			if (prev_byte_q == CH_NUL && ch == CH_COMMA) begin
				list_ended_d = 1'b1;
				ended_now    = 1'b1;
			end
			if (!ended_now && entry_q < capacity_q) begin
				prev_byte_d = ch;
				if (bracket_open_q) begin
					if (ch == CH_RPAREN) begin
						has_event              = 1'b1;
						event_word.event_res   = EV_CLOSE;
						event_word.entry_count = entry_q + 8'd1;
						bracket_open_d         = 1'b0;
						term_d                 = TERM_STATUS;
						name_pos_d             = '0;
						status_acc_d           = '0;
						number_acc_d           = '0;
						entry_d                = entry_q + 8'd1;
					end else if (ch == CH_COMMA) begin
						term_d     = term_q + 2'd1;
						name_pos_d = '0;
					end else if (ch != CH_QUOTE) begin
						case (term_q)
							TERM_STATUS: begin
								has_event            = 1'b1;
								event_word.event_res = EV_STATUS;
								event_word.acc_value = {24'd0, status_next};
								status_acc_d         = status_next;
							end
							TERM_LONG: begin
								if (name_pos_q < LONG_POS_LIMIT) begin
									has_event             = 1'b1;
									event_word.event_res  = EV_LONG_CHAR;
									event_word.char_pos   = name_pos_q;
									event_word.char_value = ch;
									name_pos_d            = name_pos_q + 6'd1;
								end
							end
							TERM_SHORT: begin
								if (name_pos_q < SHORT_POS_LIMIT) begin
									has_event             = 1'b1;
									event_word.event_res  = EV_SHORT_CHAR;
									event_word.char_pos   = name_pos_q;
									event_word.char_value = ch;
									name_pos_d            = name_pos_q + 6'd1;
								end
							end
							default: begin
								has_event            = 1'b1;
								event_word.event_res = EV_NUMBER;
								event_word.acc_value = number_next;
								number_acc_d         = number_next;
							end
						endcase
					end
				end else begin
					// outside brackets: open a group, or a double comma ends the list
					if (ch == CH_LPAREN) begin
						bracket_open_d = 1'b1;
					end else if (ch == CH_COMMA && prev_byte_q == CH_COMMA) begin
						list_ended_d = 1'b1;
					end
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_word;
		end
	end

	// parser state and list capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bracket_open_q <= 1'b0;
			list_ended_q   <= 1'b0;
			term_q         <= TERM_STATUS;
			name_pos_q     <= '0;
			prev_byte_q    <= CH_NUL;
			entry_q        <= '0;
			status_acc_q   <= '0;
			number_acc_q   <= '0;
			capacity_q     <= CAPACITY_RESET;
		end else begin
			if (step_adv) begin
				bracket_open_q <= bracket_open_d;
				list_ended_q   <= list_ended_d;
				term_q         <= term_d;
				name_pos_q     <= name_pos_d;
				prev_byte_q    <= prev_byte_d;
				entry_q        <= entry_d;
				status_acc_q   <= status_acc_d;
				number_acc_q   <= number_acc_d;
			end
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
		end
	end

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (step_adv && has_event) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_adv && has_event) begin
			rsp_word <= event_word;
		end
	end

endmodule

// File: hw/rtl/ospl_checker.sv
// ----------------------------------------------------------------------------
// ospl_checker
// Port-level checks of the operator scan list parser, bound to the top level.
// ----------------------------------------------------------------------------
module ospl_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input ospl_pkg::ospl_rsp_t rsp_word
);
	import ospl_pkg::*;

	// a stalled event word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("event word changed while stalled");

	// entry close reports the count one past the closed entry
	a_close_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.event_res == EV_CLOSE
		|-> rsp_word.entry_count == rsp_word.entry_index + 8'd1)
		else $error("entry close count mismatch");

	// status update carries only the low byte and a zero char position
	a_status_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.event_res == EV_STATUS
		|-> rsp_word.acc_value[31:8] == 24'd0 && rsp_word.char_pos == 6'd0)
		else $error("status update out of range");

	// name characters stay within the buffers
	a_name_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_word.event_res == EV_LONG_CHAR
			|| rsp_word.event_res == EV_SHORT_CHAR)
		|-> (rsp_word.event_res == EV_LONG_CHAR && rsp_word.char_pos < LONG_POS_LIMIT)
			|| (rsp_word.event_res == EV_SHORT_CHAR
				&& rsp_word.char_pos < SHORT_POS_LIMIT))
		else $error("name character beyond buffer");

endmodule

bind operator_scan_list_parser ospl_checker u_ospl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_word  (rsp_word)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the operator scan list parser. Feeds directed and
// random scan replies byte by byte, predicts every event word in a built-in
// scoreboard and compares each one field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
	import ospl_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = 8;     // input and event registers plus margin
	localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
	localparam int STALE_LIMIT   = 5000;  // cycles with no word moving

	// idle modes of the run
	localparam int MODE_FLOW   = 0;
	localparam int MODE_SEND   = 1;
	localparam int MODE_RECV   = 2;
	localparam int MODE_BOTH   = 3;

	// ------------------------------------------------------------------------
	// scoreboard: shadow parser state plus the queue of events still owed
	// ------------------------------------------------------------------------
	class scan_event_model;
		logic [7:0]  capacity;
		logic        in_bracket;
		logic        ended;
		logic [1:0]  term;
		logic [7:0]  pos;
		logic [7:0]  last_byte;
		logic [7:0]  entry;
		logic [7:0]  status;
		logic [31:0] number;
		ospl_rsp_t   pending_events[$];
		int          errors;

		function new();
			capacity = CAPACITY_RESET;
			errors   = 0;
			clear();
		endfunction

		function void clear();
			in_bracket = 1'b0;
			ended      = 1'b0;
			term       = TERM_STATUS;
			pos        = '0;
			last_byte  = CH_NUL;
			entry      = '0;
			status     = '0;
			number     = '0;
		endfunction

		function void set_capacity(logic [7:0] value);
			capacity = value;
		endfunction

		// queue up one event for the current entry
		function void owe(logic [2:0] ev, logic [5:0] cpos, logic [7:0] cval,
				logic [31:0] acc, logic [7:0] cnt);
			ospl_rsp_t e;
			e.event_res   = ev;
			e.entry_index = entry;
			e.char_pos    = cpos;
			e.char_value  = cval;
			e.acc_value   = acc;
			e.entry_count = cnt;
			pending_events.push_back(e);
		endfunction

		// advance the shadow parser by one accepted request word
		function void note_byte(ospl_req_t w);
			logic [7:0]  ch;
			logic [31:0] digit;
			logic [31:0] sum;
			ch    = w.byte_value;
			digit = {24'd0, ch} - 32'd48;
			if (w.operation == OP_RESTART) begin
				clear();
				return;
			end
			// start of reply: spaces skipped, a comma ends the list
			if (last_byte == CH_NUL) begin
				if (ch == CH_SPACE)
					return;
				if (ch == CH_COMMA)
					ended = 1'b1;
			end
			if (ended || entry >= capacity)
				return;
			if (in_bracket) begin
				if (ch == CH_RPAREN) begin
					owe(EV_CLOSE, '0, '0, '0, entry + 8'd1);
					in_bracket = 1'b0;
					term       = TERM_STATUS;
					pos        = '0;
					status     = '0;
					number     = '0;
					entry      = entry + 8'd1;
				end else if (ch == CH_COMMA) begin
					term = term + 2'd1;
					pos  = '0;
				end else if (ch != CH_QUOTE) begin
					case (term)
						TERM_STATUS: begin
							sum    = 32'd10 * {24'd0, status} + digit;
							status = sum[7:0];
							owe(EV_STATUS, '0, '0, {24'd0, status}, '0);
						end
						TERM_LONG: begin
							if (pos < 8'(LONG_NAME_LEN - 1)) begin
								owe(EV_LONG_CHAR, pos[5:0], ch, '0, '0);
								pos = pos + 8'd1;
							end
						end
						TERM_SHORT: begin
							if (pos < 8'(SHORT_NAME_LEN - 1)) begin
								owe(EV_SHORT_CHAR, pos[5:0], ch, '0, '0);
								pos = pos + 8'd1;
							end
						end
						default: begin
							number = 32'd10 * number + digit;
							owe(EV_NUMBER, '0, '0, number, '0);
						end
					endcase
				end
			end else begin
				if (ch == CH_LPAREN)
					in_bracket = 1'b1;
				else if (ch == CH_COMMA && last_byte == CH_COMMA)
					ended = 1'b1;
			end
			last_byte = ch;
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_event(ospl_rsp_t got);
			ospl_rsp_t want;
			if (pending_events.size() == 0) begin
				$error("event word with nothing expected: 0x%0h", got);
				errors++;
				return;
			end
			want = pending_events.pop_front();
			compare("event_res", 32'(want.event_res), 32'(got.event_res));
			compare("entry_index", 32'(want.entry_index), 32'(got.entry_index));
			compare("char_pos", 32'(want.char_pos), 32'(got.char_pos));
			compare("char_value", 32'(want.char_value), 32'(got.char_value));
			compare("acc_value", want.acc_value, got.acc_value);
			compare("entry_count", 32'(want.entry_count), 32'(got.entry_count));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// signals; the ones driven by the bench are known from time zero
	// ------------------------------------------------------------------------
	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	ospl_req_t req_word  = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	ospl_rsp_t rsp_word;
	logic      cfg_we    = 1'b0;
	logic [7:0] cfg_data = '0;

	scan_event_model board;
	ospl_req_t       byte_plan[$];
	int              idle_mode    = MODE_FLOW;
	int              hold_trigger = 0;    // bumped by the main flow, seen by the receiver

	operator_scan_list_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	// 20 ns clock
	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic bit chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// sender rests with a 69 percent chance alone, 30 percent when both sides idle
	function automatic bit sender_rests();
		case (idle_mode)
			MODE_SEND: return chance(69);
			MODE_BOTH: return chance(30);
			default:   return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_rests();
		case (idle_mode)
			MODE_RECV: return chance(69);
			MODE_BOTH: return chance(30);
			default:   return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// stimulus building: replies are pushed byte by byte onto byte_plan
	// ------------------------------------------------------------------------
	function automatic void plan_byte(logic [7:0] b);
		ospl_req_t w;
		w.operation  = OP_PARSE;
		w.byte_value = b;
		byte_plan.push_back(w);
	endfunction

	// the byte of a restart word is don't-care, so make it random
	function automatic void plan_restart();
		ospl_req_t w;
		w.operation  = OP_RESTART;
		w.byte_value = 8'($urandom_range(0, 255));
		byte_plan.push_back(w);
	endfunction

	function automatic logic [7:0] name_char();
		if (chance(10))
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h41, 8'h7a));
	endfunction

	// digits of a numeric term, now and then a stray non-digit
	function automatic void plan_digits(int count);
		repeat (count) begin
			if (chance(5))
				plan_byte(8'($urandom_range(0, 255)));
			else
				plan_byte(CH_ZERO + 8'($urandom_range(0, 9)));
		end
	endfunction

	// mostly short names, some running past the name buffer
	function automatic void plan_name();
		int len;
		len = chance(15) ? $urandom_range(17, 24) : $urandom_range(0, 8);
		plan_byte(CH_QUOTE);
		repeat (len)
			plan_byte(name_char());
		plan_byte(CH_QUOTE);
	endfunction

	// one (stat,"long","short",num) group
	function automatic void plan_group();
		plan_byte(CH_LPAREN);
		plan_digits($urandom_range(0, 3));
		plan_byte(CH_COMMA);
		plan_name();
		plan_byte(CH_COMMA);
		plan_name();
		plan_byte(CH_COMMA);
		plan_digits(chance(10) ? $urandom_range(9, 14) : $urandom_range(0, 5));
		plan_byte(CH_RPAREN);
	endfunction

	// special characters favored in noise
	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 7))
			0: return CH_SPACE;
			1: return CH_COMMA;
			2: return CH_LPAREN;
			3: return CH_RPAREN;
			4: return CH_QUOTE;
			5: return CH_NUL;
			6: return CH_ZERO + 8'($urandom_range(0, 9));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// a whole reply: mostly well formed, the rest broken or pure noise
	function automatic void plan_reply();
		int groups;
		if (chance(85)) begin
			plan_restart();
			repeat ($urandom_range(0, 2))
				plan_byte(CH_SPACE);
			groups = $urandom_range(1, 5);
			for (int g = 0; g < groups; g++) begin
				if (g > 0)
					plan_byte(CH_COMMA);
				if (chance(8))
					plan_byte(noise_char());
				plan_group();
			end
			// list terminator and some trailing bytes that must be ignored
			if (chance(50)) begin
				plan_byte(CH_COMMA);
				plan_byte(CH_COMMA);
				repeat ($urandom_range(0, 3))
					plan_byte(noise_char());
			end
		end else begin
			if (chance(50))
				plan_restart();
			repeat ($urandom_range(5, 20))
				plan_byte(chance(50) ? 8'($urandom_range(0, 255)) : noise_char());
		end
	endfunction

	// directed walk through the corner cases
	function automatic void plan_directed();
		plan_restart();
		plan_byte(CH_SPACE);        // skipped at reply start
		plan_byte(CH_LPAREN);
		plan_byte(8'h39);           // status '9'
		plan_byte(8'h78);           // non-digit still accumulated into status
		plan_byte(CH_COMMA);
		plan_byte(CH_QUOTE);        // quote inside bracket, no event
		plan_byte(8'hff);           // top byte value as long name char
		plan_byte(CH_QUOTE);
		plan_byte(CH_COMMA);
		plan_byte(CH_NUL);          // zero byte as short name char
		plan_byte(CH_SPACE);        // previous byte is zero again, so skipped
		plan_byte(CH_COMMA);        // and a comma now ends the list
		plan_byte(8'h41);           // ignored, list ended
		plan_restart();
		plan_byte(CH_COMMA);        // leading comma ends the list
		plan_byte(CH_LPAREN);       // ignored
		plan_restart();
		plan_byte(CH_LPAREN);
		plan_byte(CH_COMMA);
		plan_byte(CH_COMMA);
		plan_byte(CH_COMMA);        // term three, the number
		plan_byte(8'h39);
		plan_byte(CH_COMMA);        // term counter wraps back to status
		plan_byte(8'h31);
		plan_byte(CH_RPAREN);       // entry closed
		plan_byte(CH_COMMA);
		plan_byte(CH_COMMA);        // two commas outside brackets end the list
		plan_restart();
	endfunction

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// offer one request word, with optional idle cycles in front
	task automatic send_word(input ospl_req_t w);
		while (sender_rests()) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		// taken at this edge
		board.note_byte(w);
	endtask

	task automatic send_plan();
		while (byte_plan.size() != 0)
			send_word(byte_plan.pop_front());
		req_valid <= 1'b0;
	endtask

	// wait until every owed event is out, then let the pipe settle
	task automatic drain();
		while (board.pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [7:0] value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		board.set_capacity(value);
	endtask

	// receiver: checks each taken event word and decides the next stall;
	// a hold-off request makes it stall for a long counted stretch
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				board.check_event(rsp_word);
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= receiver_rests();
			end
		end
	end

	// watchdog: too long without any word moving on either side
	initial begin : watchdog
		int stale;
		stale = 0;
		while (stale < STALE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				stale = 0;
			else
				stale++;
		end
		$display("FAIL operator_scan_list_parser");
		$finish;
	end

	// ------------------------------------------------------------------------
	// main flow
	// ------------------------------------------------------------------------
	initial begin : main_flow
		logic [7:0] caps [8];
		logic [7:0] cap;
		int         target;
		board = new();
		// capacity per phase; phase 0 keeps the reset value
		caps = '{8'd16, 8'd255, 8'd0, 8'd1, 8'd2, 8'd0, 8'd255, 8'd7};

		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		plan_directed();
		send_plan();
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			cap = (phase == 5) ? 8'($urandom_range(3, 254)) : caps[phase];
			if (phase != 0)
				write_capacity(cap);
			idle_mode = phase % 4;
			// long receiver hold-off while the sender keeps offering
			if (phase == 4)
				hold_trigger++;
			// a zero capacity list ignores nearly everything, keep it short
			target = (cap == 8'd0) ? 80 : 170;
			while (byte_plan.size() < target)
				plan_reply();
			send_plan();
			drain();
		end

		if (board.errors == 0)
			$display("PASS operator_scan_list_parser");
		else
			$display("FAIL operator_scan_list_parser");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/ospl_pkg.sv
hw/rtl/operator_scan_list_parser.sv
hw/rtl/ospl_checker.sv
test/tb_top.sv
